/* hdl/cpdi_pkg.sv */
// Shared types and constants for the CP949 stream decoder and table indexer.
package cpdi_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_DIRECT = 2'd0;
	localparam logic [1:0] KIND_HANGUL = 2'd1;
	localparam logic [1:0] KIND_SYMBOL = 2'd2;
	localparam logic [1:0] KIND_HANJA  = 2'd3;

	// Fixed code points and index bases.
	localparam logic [15:0] CP_QUESTION   = 16'h003F;
	localparam logic [15:0] CP_JAMO_BASE  = 16'h3131;
	localparam logic [15:0] ROW_LEN       = 16'd94;
	localparam logic [15:0] EXT_ROW_LEN_A = 16'd178;
	localparam logic [15:0] EXT_ROW_LEN_B = 16'd84;
	localparam logic [15:0] HANGUL_EXT_A  = 16'd2350;
	localparam logic [15:0] HANGUL_EXT_B  = 16'd8046;
	localparam logic [15:0] HANGUL_EXT_C  = 16'd11154;

	// Most results one byte can cause.
	localparam int MAX_RESULTS = 3;

	// One result word.
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] value;
		logic        last;
	} result_t;

	// All results caused by one byte, in order.
	typedef struct packed {
		logic [1:0]                  count;
		result_t [MAX_RESULTS-1:0]   res;
	} batch_t;

endpackage

/* hdl/cpdi_if.sv */
// Stream interfaces for the byte input channel and the result output channel.
interface cpdi_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_string;

	modport source (output valid, output data_byte, output end_of_string, input ready);
	modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface cpdi_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] value;
	logic        last;

	modport source (output valid, output kind, output value, output last, input ready);
	modport sink (input valid, input kind, input value, input last, output ready);
endinterface

/* hdl/cpdi_decode.sv */
// Combinational decode of one byte against the held lead byte into a result batch.
module cpdi_decode (
	input  logic                 lead_pending,
	input  logic [7:0]           lead_value,
	input  logic [7:0]           data_byte,
	input  logic                 end_of_string,
	output cpdi_pkg::batch_t     batch,
	output logic                 hold_lead
);

	logic        std_trail;
	logic        ext_ok;
	logic [7:0]  ext_pos;
	logic        pair_ok;
	logic [1:0]  pair_kind;
	logic [15:0] pair_value;
	logic [15:0] trail_std;
	logic [1:0]  n;
	logic        fresh;
	logic        ended;
	logic        hold;

	// Trail classification and compact position in the extended ranges.
	always_comb begin
		std_trail = (data_byte >= 8'hA1) && (data_byte <= 8'hFE);
		trail_std = 16'(data_byte - 8'hA1);
		ext_ok    = 1'b1;
		if ((data_byte >= 8'h41) && (data_byte <= 8'h5A)) begin
			ext_pos = data_byte - 8'h41;
		end else if ((data_byte >= 8'h61) && (data_byte <= 8'h7A)) begin
			ext_pos = data_byte - 8'h47;
		end else if ((data_byte >= 8'h81) && (data_byte <= 8'hFE)) begin
			ext_pos = data_byte - 8'h4D;
		end else begin
			ext_pos = 8'd0;
			ext_ok  = 1'b0;
		end
	end

	// Pair mapping, checked in priority order.
	always_comb begin
		pair_ok    = 1'b1;
		pair_kind  = cpdi_pkg::KIND_HANGUL;
		pair_value = 16'd0;
		if ((lead_value == 8'hA4) && std_trail && (data_byte <= 8'hD3)) begin
			pair_kind  = cpdi_pkg::KIND_DIRECT;
			pair_value = cpdi_pkg::CP_JAMO_BASE + trail_std;
		end else if ((lead_value >= 8'hB0) && (lead_value <= 8'hC8) && std_trail) begin
			pair_value = 16'(lead_value - 8'hB0) * cpdi_pkg::ROW_LEN + trail_std;
		end else if ((lead_value >= 8'h81) && (lead_value <= 8'hA0) && ext_ok) begin
			pair_value = cpdi_pkg::HANGUL_EXT_A
				+ 16'(lead_value - 8'h81) * cpdi_pkg::EXT_ROW_LEN_A + 16'(ext_pos);
		end else if ((lead_value >= 8'hA1) && (lead_value <= 8'hC5) && ext_ok
				&& (data_byte <= 8'hA0)) begin
			pair_value = cpdi_pkg::HANGUL_EXT_B
				+ 16'(lead_value - 8'hA1) * cpdi_pkg::EXT_ROW_LEN_B + 16'(ext_pos);
		end else if ((lead_value == 8'hC6) && (data_byte >= 8'h41) && (data_byte <= 8'h52)) begin
			pair_value = cpdi_pkg::HANGUL_EXT_C + 16'(data_byte - 8'h41);
		end else if ((lead_value >= 8'hA1) && (lead_value <= 8'hAC) && std_trail) begin
			pair_kind  = cpdi_pkg::KIND_SYMBOL;
			pair_value = 16'(lead_value - 8'hA1) * cpdi_pkg::ROW_LEN + trail_std;
		end else if ((lead_value >= 8'hCA) && (lead_value <= 8'hFD) && std_trail) begin
			pair_kind  = cpdi_pkg::KIND_HANJA;
			pair_value = 16'(lead_value - 8'hCA) * cpdi_pkg::ROW_LEN + trail_std;
		end else begin
			pair_ok = 1'b0;
		end
	end

	// Build the ordered list of results for this byte.
	always_comb begin
		batch = '0;
		n     = 2'd0;
		fresh = !lead_pending;
		ended = 1'b0;
		hold  = 1'b0;
		// A held lead byte is paired with this byte first.
		if (lead_pending) begin
			if (pair_ok) begin
				batch.res[n] = '{kind: pair_kind, value: pair_value, last: 1'b0};
			end else begin
				batch.res[n] = '{kind: cpdi_pkg::KIND_DIRECT, value: cpdi_pkg::CP_QUESTION,
					last: 1'b0};
				fresh = 1'b1;
			end
			n = n + 2'd1;
		end
		// The byte taken on its own: terminator, ASCII or a new lead.
		if (fresh) begin
			if (data_byte == 8'h00) begin
				batch.res[n] = '{kind: cpdi_pkg::KIND_DIRECT, value: 16'd0, last: 1'b1};
				n     = n + 2'd1;
				ended = 1'b1;
			end else if (!data_byte[7]) begin
				batch.res[n] = '{kind: cpdi_pkg::KIND_DIRECT, value: 16'(data_byte),
					last: 1'b0};
				n = n + 2'd1;
			end else begin
				hold = 1'b1;
			end
		end
		// End of string flushes a dangling lead and closes the string.
		if (end_of_string && !ended) begin
			if (hold) begin
				batch.res[n] = '{kind: cpdi_pkg::KIND_DIRECT, value: cpdi_pkg::CP_QUESTION,
					last: 1'b0};
				n    = n + 2'd1;
				hold = 1'b0;
			end
			batch.res[n] = '{kind: cpdi_pkg::KIND_DIRECT, value: 16'd0, last: 1'b1};
			n = n + 2'd1;
		end
		batch.count = n;
		hold_lead   = hold;
	end

endmodule

/* hdl/cpdi_result_seq.sv */
// Result register that holds one batch and hands out one word per ready cycle.
module cpdi_result_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  cpdi_pkg::batch_t      batch,
	output logic                  load_ok,
	cpdi_out_if.source            result
);

	cpdi_pkg::result_t [cpdi_pkg::MAX_RESULTS-1:0] res_q;
	logic [1:0]        cnt_q;
	logic [1:0]        idx_q;
	cpdi_pkg::result_t cur;
	logic              final_take;

	// Words still waiting in the batch.
	assign result.valid = (idx_q != cnt_q);
	assign final_take   = result.valid && result.ready && (idx_q == cnt_q - 2'd1);
	assign load_ok      = !result.valid || final_take;

	// Select the current word.
	always_comb begin
		case (idx_q)
			2'd0:    cur = res_q[0];
			2'd1:    cur = res_q[1];
			2'd2:    cur = res_q[2];
			default: cur = res_q[0];
		endcase
	end

	assign result.kind  = cur.kind;
	assign result.value = cur.value;
	assign result.last  = cur.last;

	// Batch payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= batch.res;
		end
	end

	// Count and read position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= batch.count;
			idx_q <= 2'd0;
		end else if (result.valid && result.ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// The read position never passes the count.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= cnt_q) else $error("read position beyond batch count");

	// A terminating word is always the final word of its batch.
	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.last |-> idx_q == cnt_q - 2'd1)
		else $error("terminator is not the final word of its batch");

	// A batch with no words leaves the output idle.
	a_empty_batch: assert property (@(posedge clk) disable iff (!arst_n)
		load && batch.count == 2'd0 |=> !result.valid)
		else $error("empty batch produced output");

endmodule

/* hdl/cp949_stream_decode_indexer_top.sv */
// Top level of the CP949 stream decoder and mapping-table indexer.
//
// Usage: CP949 bytes enter on the stream channel, one word per byte, with
// end_of_string marking the last byte of a string of given length. Results
// leave on the result channel: kind 0 is a direct code point, kinds 1 to 3
// are indices into the Hangul, symbol and Hanja mapping tables; last marks
// the terminating zero of a string.
// Each byte causes zero to three result words. Its results are decoded in
// the cycle it is accepted and appear in the cycle after, one word per cycle
// while the receiver is ready. A byte is accepted in every cycle while each
// byte yields at most one word; a byte that yields more words occupies the
// result register until its final word is taken, and the next byte is
// accepted in that same cycle. A lead byte with nothing to emit is accepted
// with no output. When the receiver stalls, the current word holds and
// input is refused once the batch register is full. Reset clears the held
// lead byte and empties the result register; nothing is pending afterwards.
module cp949_stream_decode_indexer_top (
	input  logic        clk,
	input  logic        arst_n,
	cpdi_in_if.sink     stream,
	cpdi_out_if.source  result
);

	logic             lead_pending_q;
	logic [7:0]       lead_value_q;
	cpdi_pkg::batch_t batch;
	logic             hold_lead;
	logic             load_ok;
	logic             accept;

	assign stream.ready = load_ok;
	assign accept       = stream.valid && load_ok;

	// Decode of the incoming byte.
	cpdi_decode u_decode (
		.lead_pending  (lead_pending_q),
		.lead_value    (lead_value_q),
		.data_byte     (stream.data_byte),
		.end_of_string (stream.end_of_string),
		.batch         (batch),
		.hold_lead     (hold_lead)
	);

	// Result register and output sequencing.
	cpdi_result_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.batch   (batch),
		.load_ok (load_ok),
		.result  (result)
	);

	// Held lead byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
			lead_value_q   <= 8'd0;
		end else if (accept) begin
			lead_pending_q <= hold_lead;
			lead_value_q   <= stream.data_byte;
		end
	end

	// A string end always drops the held lead byte.
	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && stream.end_of_string |=> !lead_pending_q)
		else $error("lead byte survived end of string");

endmodule

/* tb/tb_cp949_stream_decode_indexer_top.sv */
// Self-checking testbench for the CP949 stream decoder and table indexer.
module tb_cp949_stream_decode_indexer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cpdi_pkg::*;

	// One input word: a string byte and its end-of-string flag.
	typedef struct {
		logic [7:0] data_byte;
		logic       end_of_string;
	} cp_byte_t;

	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_WAIT  = 12;
	localparam int RANDOM_BYTES = 210;

	logic clk;
	logic arst_n;

	cpdi_in_if  stream_ch ();
	cpdi_out_if result_ch ();

	cp949_stream_decode_indexer_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.result (result_ch)
	);

	// Bytes waiting to be driven and result words waiting to be seen.
	cp_byte_t byte_queue[$];
	result_t  due_words[$];

	// Predictor copy of the held lead byte.
	bit         held_valid;
	logic [7:0] held_byte;

	int mismatches;
	int idle_cycles;
	int send_idle;
	int send_calm;
	int recv_stall;
	int recv_calm;

	// Clock: 8 ns period.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Gap length: mostly none or short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic void push_word(logic [1:0] k, logic [15:0] v, logic l);
		result_t w;
		w.kind  = k;
		w.value = v;
		w.last  = l;
		due_words.push_back(w);
	endfunction

	// Position of a trail byte among the extended-range trails, or -1.
	function automatic int ext_trail_pos(logic [7:0] t);
		if (t >= 8'h41 && t <= 8'h5A) return int'(t) - 'h41;
		if (t >= 8'h61 && t <= 8'h7A) return int'(t) - 'h41 - 6;
		if (t >= 8'h81 && t <= 8'hFE) return int'(t) - 'h41 - 12;
		return -1;
	endfunction

	// Maps a lead/trail pair; returns 0 when the pair is not valid.
	function automatic bit map_pair(input logic [7:0] ld, input logic [7:0] tr,
			output logic [1:0] k, output logic [15:0] v);
		bit std_trail;
		int c;
		std_trail = (tr >= 8'hA1 && tr <= 8'hFE);
		c = ext_trail_pos(tr);
		k = KIND_DIRECT;
		v = '0;
		if (ld == 8'hA4 && tr >= 8'hA1 && tr <= 8'hD3) begin
			k = KIND_DIRECT;
			v = 16'(int'(CP_JAMO_BASE) + int'(tr) - 'hA1);
			return 1'b1;
		end
		if (ld >= 8'hB0 && ld <= 8'hC8 && std_trail) begin
			k = KIND_HANGUL;
			v = 16'((int'(ld) - 'hB0) * 94 + int'(tr) - 'hA1);
			return 1'b1;
		end
		if (ld >= 8'h81 && ld <= 8'hA0 && c >= 0) begin
			k = KIND_HANGUL;
			v = 16'(2350 + (int'(ld) - 'h81) * 178 + c);
			return 1'b1;
		end
		if (ld >= 8'hA1 && ld <= 8'hC5 && c >= 0 && tr <= 8'hA0) begin
			k = KIND_HANGUL;
			v = 16'(2350 + 5696 + (int'(ld) - 'hA1) * 84 + c);
			return 1'b1;
		end
		if (ld == 8'hC6 && tr >= 8'h41 && tr <= 8'h52) begin
			k = KIND_HANGUL;
			v = 16'(2350 + 5696 + 3108 + int'(tr) - 'h41);
			return 1'b1;
		end
		if (ld >= 8'hA1 && ld <= 8'hAC && std_trail) begin
			k = KIND_SYMBOL;
			v = 16'((int'(ld) - 'hA1) * 94 + int'(tr) - 'hA1);
			return 1'b1;
		end
		if (ld >= 8'hCA && ld <= 8'hFD && std_trail) begin
			k = KIND_HANJA;
			v = 16'((int'(ld) - 'hCA) * 94 + int'(tr) - 'hA1);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// A byte with no lead held; returns 1 if it ended the string.
	function automatic bit take_fresh(logic [7:0] b);
		if (b == 8'h00) begin
			push_word(KIND_DIRECT, 16'h0000, 1'b1);
			held_valid = 1'b0;
			held_byte  = 8'h00;
			return 1'b1;
		end
		if (b < 8'h80) begin
			push_word(KIND_DIRECT, {8'h00, b}, 1'b0);
			return 1'b0;
		end
		held_valid = 1'b1;
		held_byte  = b;
		return 1'b0;
	endfunction

	// Predicts the result words of one accepted byte.
	function automatic void decode_byte(logic [7:0] b, logic eos);
		bit         ended;
		logic [7:0] ld;
		logic [1:0] k;
		logic [15:0] v;
		if (held_valid) begin
			ld = held_byte;
			held_valid = 1'b0;
			held_byte  = 8'h00;
			if (map_pair(ld, b, k, v)) begin
				push_word(k, v, 1'b0);
				ended = 1'b0;
			end else begin
				push_word(KIND_DIRECT, CP_QUESTION, 1'b0);
				ended = take_fresh(b);
			end
		end else begin
			ended = take_fresh(b);
		end
		if (eos && !ended) begin
			if (held_valid) begin
				push_word(KIND_DIRECT, CP_QUESTION, 1'b0);
				held_valid = 1'b0;
				held_byte  = 8'h00;
			end
			push_word(KIND_DIRECT, 16'h0000, 1'b1);
		end
	endfunction

	task automatic add_byte(logic [7:0] b, logic eos);
		cp_byte_t item;
		item.data_byte     = b;
		item.end_of_string = eos;
		byte_queue.push_back(item);
	endtask

	// Trail byte from its position among the extended-range trails.
	function automatic logic [7:0] ext_trail_byte(int c);
		if (c < 26) return 8'(8'h41 + c);
		if (c < 52) return 8'(8'h61 + c - 26);
		return 8'(8'h81 + c - 52);
	endfunction

	// A well-formed pair from one of the mapped ranges.
	task automatic add_valid_pair();
		logic [7:0] ld;
		logic [7:0] tr;
		case ($urandom_range(0, 6))
			0: begin
				ld = 8'hA4;
				tr = 8'(8'hA1 + $urandom_range(0, 50));
			end
			1: begin
				ld = 8'(8'hB0 + $urandom_range(0, 24));
				tr = 8'(8'hA1 + $urandom_range(0, 93));
			end
			2: begin
				ld = 8'(8'h81 + $urandom_range(0, 31));
				tr = ext_trail_byte($urandom_range(0, 177));
			end
			3: begin
				ld = 8'(8'hA1 + $urandom_range(0, 36));
				tr = ext_trail_byte($urandom_range(0, 83));
			end
			4: begin
				ld = 8'hC6;
				tr = 8'(8'h41 + $urandom_range(0, 17));
			end
			5: begin
				ld = 8'(8'hA1 + $urandom_range(0, 11));
				tr = 8'(8'hA1 + $urandom_range(0, 93));
			end
			default: begin
				ld = 8'(8'hCA + $urandom_range(0, 51));
				tr = 8'(8'hA1 + $urandom_range(0, 93));
			end
		endcase
		add_byte(ld, 1'b0);
		add_byte(tr, 1'b0);
	endtask

	// Driver: presents queued bytes with random gaps between words.
	always @(posedge clk) begin
		if (arst_n) begin
			if (stream_ch.valid && stream_ch.ready)
				decode_byte(stream_ch.data_byte, stream_ch.end_of_string);
			if (!stream_ch.valid || stream_ch.ready) begin
				if (send_idle > 0) begin
					stream_ch.valid <= 1'b0;
					send_idle <= send_idle - 1;
				end else if (byte_queue.size() > 0) begin
					stream_ch.valid         <= 1'b1;
					stream_ch.data_byte     <= byte_queue[0].data_byte;
					stream_ch.end_of_string <= byte_queue[0].end_of_string;
					void'(byte_queue.pop_front());
					if (send_calm > 0) begin
						send_calm <= send_calm - 1;
						send_idle <= 0;
					end else begin
						if ($urandom_range(0, 99) < 4)
							send_calm <= $urandom_range(15, 40);
						send_idle <= pick_gap();
					end
				end else begin
					stream_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result word and stalls the receiver at random.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (due_words.size() == 0) begin
					$error("unexpected result word: kind %0d value %0h last %0d",
						result_ch.kind, result_ch.value, result_ch.last);
					mismatches++;
				end else begin
					want = due_words.pop_front();
					if (result_ch.kind !== want.kind) begin
						$error("kind mismatch: expected %0d, actual %0d",
							want.kind, result_ch.kind);
						mismatches++;
					end
					if (result_ch.value !== want.value) begin
						$error("value mismatch: expected %0h, actual %0h",
							want.value, result_ch.value);
						mismatches++;
					end
					if (result_ch.last !== want.last) begin
						$error("last mismatch: expected %0d, actual %0d",
							want.last, result_ch.last);
						mismatches++;
					end
				end
			end
			if (recv_stall > 0) begin
				result_ch.ready <= 1'b0;
				recv_stall <= recv_stall - 1;
			end else begin
				result_ch.ready <= 1'b1;
				if (recv_calm > 0) begin
					recv_calm <= recv_calm - 1;
				end else if ($urandom_range(0, 99) < 3) begin
					recv_calm <= $urandom_range(15, 40);
				end else if ($urandom_range(0, 99) < 30) begin
					recv_stall <= pick_gap();
				end
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		cp_byte_t str[$];
		int       nchars;
		int       r;
		int       random_count;
		arst_n                  = 1'b0;
		stream_ch.valid         = 1'b0;
		stream_ch.data_byte     = 8'h00;
		stream_ch.end_of_string = 1'b0;
		result_ch.ready         = 1'b0;
		held_valid  = 1'b0;
		held_byte   = 8'h00;
		mismatches  = 0;
		idle_cycles = 0;
		send_idle   = 0;
		send_calm   = 0;
		recv_stall  = 0;
		recv_calm   = 0;

		// Directed part: ASCII extremes, a zero byte, each range at its corners.
		add_byte(8'h7F, 1'b0);
		add_byte(8'h01, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'hA4, 1'b0); add_byte(8'hA1, 1'b0);
		add_byte(8'hA4, 1'b0); add_byte(8'hD3, 1'b0);
		add_byte(8'hB0, 1'b0); add_byte(8'hA1, 1'b0);
		add_byte(8'hC8, 1'b0); add_byte(8'hFE, 1'b0);
		add_byte(8'h81, 1'b0); add_byte(8'h41, 1'b0);
		add_byte(8'hA0, 1'b0); add_byte(8'hFE, 1'b0);
		add_byte(8'hC5, 1'b0); add_byte(8'hA0, 1'b0);
		add_byte(8'hC6, 1'b0); add_byte(8'h52, 1'b0);
		add_byte(8'hAC, 1'b0); add_byte(8'hFE, 1'b0);
		add_byte(8'hFD, 1'b0); add_byte(8'hFE, 1'b0);
		// Invalid pair whose trail FF becomes a new lead, then an ASCII trail.
		add_byte(8'h80, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'h41, 1'b0);
		// Invalid pair whose trail is the zero byte that ends the string.
		add_byte(8'hC9, 1'b0); add_byte(8'h00, 1'b0);
		// Lead byte still held at the end of a string.
		add_byte(8'hFE, 1'b1);
		// End of string on an ASCII byte and on a zero byte.
		add_byte(8'h01, 1'b1);
		add_byte(8'h00, 1'b1);

		// Random part: strings of mostly well-formed characters.
		random_count = 0;
		while (random_count < RANDOM_BYTES) begin
			str.delete();
			nchars = $urandom_range(1, 8);
			for (int i = 0; i < nchars; i++) begin
				r = $urandom_range(0, 99);
				if (r < 25) begin
					add_byte(8'($urandom_range(1, 127)), 1'b0);
				end else if (r < 85) begin
					add_valid_pair();
				end else if (r < 95) begin
					add_byte(8'($urandom_range(128, 255)), 1'b0);
					add_byte(8'($urandom_range(0, 255)), 1'b0);
				end else begin
					add_byte(8'($urandom_range(0, 255)), 1'b0);
				end
			end
			case ($urandom_range(0, 3))
				0: add_byte(8'h00, 1'($urandom_range(0, 1)));
				1, 2: byte_queue[byte_queue.size()-1].end_of_string = 1'b1;
				default: add_byte(8'($urandom_range(128, 255)), 1'b1);
			endcase
			random_count = byte_queue.size();
		end

		// Release reset between clock edges.
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for all bytes to be taken and all result words to arrive.
		do @(negedge clk);
		while (byte_queue.size() > 0 || stream_ch.valid || due_words.size() > 0);
		repeat (DRAIN_WAIT) @(negedge clk);

		if (mismatches == 0 && due_words.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
